>>> rtl/brf_pkg.sv
// brf_pkg: shared types and constants for the response fragmenter
// no dependencies; used by the interfaces, brf_outq and ble_response_fragmenter

package brf_pkg;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    localparam int BEATS_MAX = 3;

    typedef logic [1:0] brf_cnt_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
        logic       end_of_message;
        logic       last;
    } brf_beat_t;

    typedef struct packed {
        brf_cnt_t                  count;
        brf_beat_t [BEATS_MAX-1:0] beat;
    } brf_load_t;

endpackage

>>> rtl/brf_if.sv
// brf_req_if / brf_rsp_if: valid/ready channels of the response fragmenter
// depends on brf_pkg

interface brf_req_if
    import brf_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  msg_cmd;
    logic [15:0] msg_length;
    logic [7:0]  data_byte;

    modport source (output valid, req_type, msg_cmd, msg_length, data_byte, input ready);
    modport sink   (input valid, req_type, msg_cmd, msg_length, data_byte, output ready);
endinterface

interface brf_rsp_if
    import brf_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       end_of_packet;
    logic       end_of_message;
    logic       last;

    modport source (output valid, packet_byte, end_of_packet, end_of_message, last,
                    input ready);
    modport sink   (input valid, packet_byte, end_of_packet, end_of_message, last,
                    output ready);
endinterface

>>> rtl/brf_outq.sv
// brf_outq: three-entry result queue that plays out the bytes of one request
// depends on brf_pkg and brf_rsp_if

module brf_outq
    import brf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_en,
    input  brf_load_t     load,
    output logic          can_load,
    brf_rsp_if.source     rsp
);

    brf_cnt_t                  cnt_reg;
    brf_cnt_t                  cnt_next;
    brf_beat_t [BEATS_MAX-1:0] beat_reg;
    brf_beat_t [BEATS_MAX-1:0] beat_next;
    logic                      pop;

    assign pop      = rsp.valid && rsp.ready;
    assign can_load = (cnt_reg == brf_cnt_t'(0)) || ((cnt_reg == brf_cnt_t'(1)) && rsp.ready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        beat_next = beat_reg;
        if (pop)
        begin
            beat_next[0] = beat_reg[1];
            beat_next[1] = beat_reg[2];
            cnt_next     = cnt_reg - brf_cnt_t'(1);
        end
        if (load_en)
        begin
            cnt_next  = load.count;
            beat_next = load.beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign rsp.valid          = (cnt_reg != brf_cnt_t'(0));
    assign rsp.packet_byte    = beat_reg[0].packet_byte;
    assign rsp.end_of_packet  = beat_reg[0].end_of_packet;
    assign rsp.end_of_message = beat_reg[0].end_of_message;
    assign rsp.last           = beat_reg[0].last;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != brf_cnt_t'(3) || !load_en || rsp.ready)
        else $error("load over a full queue");

    a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
        load_en |-> can_load)
        else $error("load while queue busy");

    a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.last) |-> (cnt_reg == brf_cnt_t'(1)))
        else $error("last mark not on final queued byte");

    a_eom_eop: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.end_of_message) |-> rsp.end_of_packet)
        else $error("end of message without end of packet");

    a_empty_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && rsp.last && !load_en) |=> !rsp.valid)
        else $error("queue not empty after last transfer");

endmodule

>>> rtl/ble_response_fragmenter.sv
// ble_response_fragmenter: cuts response messages into link packets of PACKET_SIZE bytes
// depends on brf_pkg, brf_req_if, brf_rsp_if and brf_outq
//
// usage:
//   req carries request items: a start item (req_type 0) with command and length, or
//   one data byte (req_type 1). rsp carries one packet byte per transfer with
//   end_of_packet, end_of_message and last (final byte caused by one request).
//   a start item gives three bytes (command, length high, length low); a data item
//   gives one byte, or two when a new packet opens with its sequence byte; a data
//   item with no open message gives nothing.
//   latency: the first byte of an item is on rsp the cycle after its transfer.
//   throughput: one rsp byte per cycle while the receiver is ready; an item makes 0 to 3
//   bytes, and the pace is set by the single rsp port draining the result queue.
//   req.ready rises again in the cycle the last byte of the previous item leaves.
//   reset clears message state and empties the queue.
//   when the receiver stalls, the current byte holds and req stalls behind it.

module ble_response_fragmenter
    import brf_pkg::*;
#(
    parameter int PACKET_SIZE = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    brf_req_if.sink   req,
    brf_rsp_if.source rsp
);

    localparam int POS_W = $clog2(PACKET_SIZE + 1);

    logic             open_reg;
    logic             open_next;
    logic [15:0]      len_reg;
    logic [15:0]      len_next;
    logic [15:0]      sent_reg;
    logic [15:0]      sent_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [6:0]       pcnt_reg;
    logic [6:0]       pcnt_next;

    logic             can_load;
    logic             accept;
    brf_load_t        load;

    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic [15:0]      sent_inc;
    logic             eop;
    logic             eom;
    brf_beat_t        data_beat;
    brf_beat_t        hdr_beat;

    assign req.ready = can_load;
    assign accept    = req.valid && can_load;

    always_comb
    begin
        open_next = open_reg;
        len_next  = len_reg;
        sent_next = sent_reg;
        pos_next  = pos_reg;
        pcnt_next = pcnt_reg;
        load      = '0;
        eop       = 1'b0;
        eom       = 1'b0;
        pos_a     = (pos_reg == '0) ? POS_W'(1) : pos_reg;
        pos_b     = pos_a + POS_W'(1);
        sent_inc  = sent_reg + 16'd1;
        hdr_beat  = '{packet_byte: {1'b0, pcnt_reg - 7'd1}, end_of_packet: 1'b0,
                      end_of_message: 1'b0, last: 1'b0};
        data_beat = '{packet_byte: req.data_byte, end_of_packet: 1'b0,
                      end_of_message: 1'b0, last: 1'b1};

        if (req.req_type == REQ_START)
        begin
            len_next   = req.msg_length;
            sent_next  = '0;
            pcnt_next  = '0;
            load.count = brf_cnt_t'(3);
            load.beat[0] = '{packet_byte: req.msg_cmd, end_of_packet: 1'b0,
                             end_of_message: 1'b0, last: 1'b0};
            if (req.msg_length == 16'd0)
            begin
                load.beat[1] = '{packet_byte: 8'd0, end_of_packet: 1'b0,
                                 end_of_message: 1'b0, last: 1'b0};
                load.beat[2] = '{packet_byte: 8'd0, end_of_packet: 1'b1,
                                 end_of_message: 1'b1, last: 1'b1};
                open_next = 1'b0;
                pos_next  = '0;
            end
            else
            begin
                load.beat[1] = '{packet_byte: req.msg_length[15:8], end_of_packet: 1'b0,
                                 end_of_message: 1'b0, last: 1'b0};
                load.beat[2] = '{packet_byte: req.msg_length[7:0], end_of_packet: 1'b0,
                                 end_of_message: 1'b0, last: 1'b1};
                open_next = 1'b1;
                pos_next  = POS_W'(3);
            end
        end
        else if (open_reg)
        begin
            sent_next = sent_inc;
            pos_next  = pos_b;
            if (sent_inc == len_reg)
            begin
                eop       = 1'b1;
                eom       = 1'b1;
                open_next = 1'b0;
                pos_next  = '0;
                pcnt_next = pcnt_reg + 7'd1;
            end
            else if (pos_b >= POS_W'(PACKET_SIZE))
            begin
                eop       = 1'b1;
                pos_next  = '0;
                pcnt_next = pcnt_reg + 7'd1;
            end
            data_beat.end_of_packet  = eop;
            data_beat.end_of_message = eom;
            if (pos_reg == '0)
            begin
                load.count   = brf_cnt_t'(2);
                load.beat[0] = hdr_beat;
                load.beat[1] = data_beat;
            end
            else
            begin
                load.count   = brf_cnt_t'(1);
                load.beat[0] = data_beat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            len_reg  <= '0;
            sent_reg <= '0;
            pos_reg  <= '0;
            pcnt_reg <= '0;
        end
        else if (accept)
        begin
            open_reg <= open_next;
            len_reg  <= len_next;
            sent_reg <= sent_next;
            pos_reg  <= pos_next;
            pcnt_reg <= pcnt_next;
        end
    end

    brf_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_en  (accept),
        .load     (load),
        .can_load (can_load),
        .rsp      (rsp)
    );

endmodule

>>> sim/ble_response_fragmenter_tb.sv
// ble_response_fragmenter_tb: self-checking bench for the response fragmenter
// drives request transfers under varied idling and checks every packet byte
// against an in-bench fragmenter model; depends on brf_pkg, both interfaces, ble_response_fragmenter

module ble_response_fragmenter_tb;

    import brf_pkg::*;

    localparam int PACKET_SIZE = 64;
    localparam int DRAIN_PAD   = 16;

    typedef struct {
        logic        kind;
        logic [7:0]  cmd;
        logic [15:0] len;
        logic [7:0]  dbyte;
        logic        hold;
    } request_t;

    logic clk = 1'b0;
    logic rst_n;

    brf_req_if req_ch ();
    brf_rsp_if rsp_ch ();

    ble_response_fragmenter #(
        .PACKET_SIZE (PACKET_SIZE)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    request_t  req_backlog [$];
    brf_beat_t pending_beats [$];

    int send_idle;
    int recv_idle;
    int items_queued;
    int items_taken;
    int predicted_cnt;
    int received_cnt;
    int errors;
    int messages_seen;
    int seq_wraps;

    logic        frag_open;
    logic [7:0]  frag_cmd;
    logic [15:0] frag_len;
    logic [15:0] frag_sent;
    int          frag_pos;
    logic [7:0]  frag_pkts;

    always #4 clk = ~clk;

    task automatic fragment_request(input logic kind, input logic [7:0] cmd,
                                    input logic [15:0] len, input logic [7:0] dbyte,
                                    output int made);
        brf_beat_t  beats [BEATS_MAX];
        logic [7:0] seq;
        logic       eop;
        logic       eom;
        made = 0;
        eop  = 1'b0;
        eom  = 1'b0;
        if (kind == REQ_START)
        begin
            frag_cmd  = cmd;
            frag_len  = len;
            frag_sent = '0;
            frag_pkts = '0;
            messages_seen++;
            beats[0] = '{cmd, 1'b0, 1'b0, 1'b0};
            if (len == 16'd0)
            begin
                beats[1]  = '{8'h00, 1'b0, 1'b0, 1'b0};
                beats[2]  = '{8'h00, 1'b1, 1'b1, 1'b0};
                frag_open = 1'b0;
                frag_pos  = 0;
            end
            else
            begin
                beats[1]  = '{len[15:8], 1'b0, 1'b0, 1'b0};
                beats[2]  = '{len[7:0], 1'b0, 1'b0, 1'b0};
                frag_open = 1'b1;
                frag_pos  = 3;
            end
            made = 3;
        end
        else if (frag_open)
        begin
            // continuation packet opens with its sequence byte
            if (frag_pos == 0)
            begin
                seq = frag_pkts - 8'd1;
                if (seq == 8'd128)
                    seq_wraps++;
                beats[0] = '{{1'b0, seq[6:0]}, 1'b0, 1'b0, 1'b0};
                made     = 1;
                frag_pos = 1;
            end
            frag_sent = frag_sent + 16'd1;
            frag_pos++;
            if (frag_sent == frag_len)
            begin
                eop       = 1'b1;
                eom       = 1'b1;
                frag_open = 1'b0;
                frag_pos  = 0;
                frag_pkts = frag_pkts + 8'd1;
            end
            else if (frag_pos >= PACKET_SIZE)
            begin
                eop       = 1'b1;
                frag_pos  = 0;
                frag_pkts = frag_pkts + 8'd1;
            end
            beats[made] = '{dbyte, eop, eom, 1'b0};
            made++;
        end
        if (made > 0)
            beats[made-1].last = 1'b1;
        for (int i = 0; i < made; i++)
            pending_beats.push_back(beats[i]);
    endtask

    task automatic queue_item(input logic kind, input logic [7:0] cmd,
                              input logic [15:0] len, input logic [7:0] dbyte,
                              input logic hold);
        request_t r;
        r.kind  = kind;
        r.cmd   = cmd;
        r.len   = len;
        r.dbyte = dbyte;
        r.hold  = hold;
        req_backlog.push_back(r);
        items_queued++;
    endtask

    task automatic queue_data(input int count);
        for (int i = 0; i < count; i++)
            queue_item(REQ_DATA, 8'($urandom), 16'($urandom), 8'($urandom), 1'b0);
    endtask

    task automatic queue_message(input int len, input int bytes);
        queue_item(REQ_START, 8'($urandom), 16'(len), 8'($urandom),
                   $urandom_range(0, 19) == 0);
        queue_data(bytes);
    endtask

    task automatic queue_random_message();
        int sel;
        int len;
        int bytes;
        sel = $urandom_range(0, 99);
        if (sel < 8)
            len = 0;
        else if (sel < 85)
            len = $urandom_range(1, 10);
        else if (sel < 95)
            len = $urandom_range(58, 70);
        else
            len = $urandom_range(0, 65535);
        bytes = len;
        // abandoned message, cut short by the next start
        if (len > 300)
            bytes = $urandom_range(0, 40);
        else if ($urandom_range(0, 9) == 0)
            bytes = $urandom_range(0, len);
        queue_message(len, bytes);
        // stray bytes after the message closes
        if ($urandom_range(0, 5) == 0)
            queue_data($urandom_range(1, 2));
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || received_cnt < predicted_cnt)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        request_t nxt;
        int       made;
        if (!rst_n)
        begin
            req_ch.valid      <= 1'b0;
            req_ch.req_type   <= REQ_START;
            req_ch.msg_cmd    <= '0;
            req_ch.msg_length <= '0;
            req_ch.data_byte  <= '0;
            items_taken       <= 0;
            predicted_cnt     <= 0;
        end
        else
        begin
            made = 0;
            if (req_ch.valid && req_ch.ready)
            begin
                fragment_request(req_ch.req_type, req_ch.msg_cmd, req_ch.msg_length,
                                 req_ch.data_byte, made);
                items_taken <= items_taken + 1;
            end
            predicted_cnt <= predicted_cnt + made;
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_backlog.size() != 0 &&
                    (!req_backlog[0].hold ||
                     received_cnt + (rsp_ch.valid && rsp_ch.ready) >= predicted_cnt + made) &&
                    $urandom_range(0, 99) >= send_idle)
                begin
                    nxt = req_backlog.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= nxt.kind;
                    req_ch.msg_cmd    <= nxt.cmd;
                    req_ch.msg_length <= nxt.len;
                    req_ch.data_byte  <= nxt.dbyte;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_proc
        brf_beat_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            received_cnt <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                received_cnt <= received_cnt + 1;
                if (pending_beats.size() == 0)
                begin
                    $error("unexpected transfer: packet_byte %02h", rsp_ch.packet_byte);
                    errors++;
                end
                else
                begin
                    want = pending_beats.pop_front();
                    if (rsp_ch.packet_byte !== want.packet_byte)
                    begin
                        $error("packet_byte: expected %02h, actual %02h",
                               want.packet_byte, rsp_ch.packet_byte);
                        errors++;
                    end
                    if (rsp_ch.end_of_packet !== want.end_of_packet)
                    begin
                        $error("end_of_packet: expected %b, actual %b",
                               want.end_of_packet, rsp_ch.end_of_packet);
                        errors++;
                    end
                    if (rsp_ch.end_of_message !== want.end_of_message)
                    begin
                        $error("end_of_message: expected %b, actual %b",
                               want.end_of_message, rsp_ch.end_of_message);
                        errors++;
                    end
                    if (rsp_ch.last !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, rsp_ch.last);
                        errors++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    initial
    begin : stimulus
        int target;
        int leftover;
        frag_open     = 1'b0;
        frag_cmd      = '0;
        frag_len      = '0;
        frag_sent     = '0;
        frag_pos      = 0;
        frag_pkts     = '0;
        errors        = 0;
        items_queued  = 0;
        messages_seen = 0;
        seq_wraps     = 0;
        send_idle     = 6;
        recv_idle     = 58;
        rst_n         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no message open, zero length, abandon, both marks, stray byte
        queue_item(REQ_DATA,  8'hFF, 16'hFFFF, 8'hFF, 1'b0);
        queue_item(REQ_START, 8'h00, 16'h0000, 8'hFF, 1'b0);
        queue_item(REQ_START, 8'hFF, 16'hFFFF, 8'hFF, 1'b0);
        queue_item(REQ_DATA,  8'h00, 16'h0000, 8'h00, 1'b0);
        queue_item(REQ_DATA,  8'hFF, 16'hFFFF, 8'hFF, 1'b0);
        queue_item(REQ_START, 8'hA5, 16'h0002, 8'h00, 1'b1);
        queue_item(REQ_DATA,  8'h00, 16'hFFFF, 8'h5A, 1'b0);
        queue_item(REQ_DATA,  8'hFF, 16'h0000, 8'hC3, 1'b0);
        queue_item(REQ_DATA,  8'h12, 16'h3456, 8'h11, 1'b0);
        queue_item(REQ_START, 8'h3C, 16'h0001, 8'h00, 1'b0);
        queue_item(REQ_DATA,  8'h00, 16'h0000, 8'h7E, 1'b0);
        queue_item(REQ_START, 8'hC3, 16'h8000, 8'h00, 1'b1);
        queue_item(REQ_DATA,  8'h00, 16'h0000, 8'h80, 1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle = 58;
                recv_idle = 6;
                // packet boundaries: full and last together, one byte over, two full
                queue_message(61, 61);
                queue_message(62, 62);
                queue_message(124, 124);
            end
            else if (phase == 2)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            target = items_queued + 15;
            while (items_queued < target)
                queue_random_message();
            wait_drained();
        end

        repeat (DRAIN_PAD) @(posedge clk);
        leftover = pending_beats.size();
        if (leftover != 0)
            $error("%0d expected packet bytes never arrived", leftover);
        $display("covered %0d request transfers, %0d messages, %0d packet bytes checked",
                 items_taken, messages_seen, received_cnt);
        $display("three idle profiles, drain pauses, %0d sequence wraps", seq_wraps);
        if (errors == 0 && leftover == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
